// ===== design/lstm_cell_pointwise_update_top_macros.svh =====
// ----------------------------------------------------------------------------
// lstm cell pointwise update assertion macros
// shared property forms for the lstm cell pointwise update rtl
// ----------------------------------------------------------------------------
`ifndef LSTM_CELL_POINTWISE_UPDATE_TOP_MACROS_SVH
`define LSTM_CELL_POINTWISE_UPDATE_TOP_MACROS_SVH

// same-cycle implication, expects clk and arst_n in scope
`define LCPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcpu assertion failed");

// next-cycle implication
`define LCPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcpu assertion failed");

`endif

// ===== design/lcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpu package
// shared types, widths and the exponential table for the lstm cell update
// ----------------------------------------------------------------------------
package lcpu_pkg;

	localparam int unsigned DATA_W           = 16;
	localparam int unsigned IDX_W            = 10;
	localparam int unsigned HID_W            = 14;
	localparam int unsigned MAX_ELEMENTS_DEF = 1024;
	localparam int unsigned EXP_STEPS        = 17;
	localparam int unsigned DIV_STEPS        = 13;
	// exp steps, one operand stage, divide steps, one sign stage
	localparam int unsigned ACT_LAT          = EXP_STEPS + 1 + DIV_STEPS + 1;

	typedef enum logic {
		ACT_SIGMOID,
		ACT_TANH
	} act_fn_t;

	typedef enum logic {
		REQ_LOAD,
		REQ_STEP
	} req_t;

	// e^-(2^k / 4096) in q.30
	function automatic logic [29:0] exp_tab(input int unsigned k);
		logic [29:0] v;
		case (k)
			0:       v = 30'd1073479712;
			1:       v = 30'd1073217664;
			2:       v = 30'd1072693760;
			3:       v = 30'd1071646719;
			4:       v = 30'd1069555701;
			5:       v = 30'd1065385899;
			6:       v = 30'd1057095000;
			7:       v = 30'd1040706261;
			8:       v = 30'd1008687096;
			9:       v = 30'd947573834;
			10:      v = 30'd836230973;
			11:      v = 30'd651257337;
			12:      v = 30'd395007542;
			13:      v = 30'd145315155;
			14:      v = 30'd19666268;
			15:      v = 30'd360201;
			16:      v = 30'd121;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/lcpu_ram.sv =====
// ----------------------------------------------------------------------------
// lcpu ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lcpu_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/lcpu_act.sv =====
// ----------------------------------------------------------------------------
// lcpu activation unit
// pipelined sigmoid / tanh in q4.12: exp chain, restoring divide, sign fix
// ----------------------------------------------------------------------------
module lcpu_act (
	input  logic                   clk,
	input  logic                   en,
	input  lcpu_pkg::act_fn_t      fn,
	input  logic signed [15:0]     x,
	output logic signed [13:0]     y
);

	logic        neg_in;
	logic [15:0] mag_in;
	logic [16:0] z_in0;

	logic [30:0]         acc_s [1:17];
	logic [16:0]         z_s   [1:16];
	lcpu_pkg::act_fn_t   fn_s  [1:31];
	logic                ng_s  [1:31];
	logic [31:0]         d_s   [18:30];
	logic [43:0]         rem_s [18:30];
	logic [12:0]         q_s   [19:31];
	logic signed [13:0]  y_s32;

	logic [31:0] d_c;
	logic [30:0] half_c;
	logic [30:0] diff_c;
	logic [43:0] num_c;

	assign neg_in = x[15];
	assign mag_in = neg_in ? 16'(-x) : 16'(x);
	// tanh needs e^-2|x|
	assign z_in0  = (fn == lcpu_pkg::ACT_TANH) ? {mag_in, 1'b0} : {1'b0, mag_in};

	genvar k;
	generate
		for (k = 0; k < 17; k++) begin : g_exp
			logic [30:0]       acc_in;
			logic [16:0]       z_in;
			lcpu_pkg::act_fn_t fn_in;
			logic              ng_in;
			logic [61:0]       prod;

			if (k == 0) begin : g_first
				assign acc_in = 31'd1 << 30;
				assign z_in   = z_in0;
				assign fn_in  = fn;
				assign ng_in  = neg_in;
			end else begin : g_next
				assign acc_in = acc_s[k];
				assign z_in   = z_s[k];
				assign fn_in  = fn_s[k];
				assign ng_in  = ng_s[k];
			end

			// product rounded half up back to q.30
			assign prod = {31'd0, acc_in} * {32'd0, lcpu_pkg::exp_tab(k)} + (62'd1 << 29);

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k+1] <= z_in[k] ? prod[60:30] : acc_in;
					fn_s[k+1]  <= fn_in;
					ng_s[k+1]  <= ng_in;
				end
			end

			if (k < 16) begin : g_z
				always_ff @(posedge clk) begin
					if (en) begin
						z_s[k+1] <= z_in;
					end
				end
			end
		end
	endgenerate

	// divisor and rounded numerator
	assign d_c    = {1'b0, acc_s[17]} + (32'd1 << 30);
	assign half_c = d_c[31:1];
	assign diff_c = (31'd1 << 30) - acc_s[17];
	assign num_c  = (fn_s[17] == lcpu_pkg::ACT_TANH) ?
		({1'b0, diff_c, 12'd0} + {13'd0, half_c}) :
		((44'd1 << 42) + {13'd0, half_c});

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[18]   <= d_c;
			rem_s[18] <= num_c;
			fn_s[18]  <= fn_s[17];
			ng_s[18]  <= ng_s[17];
		end
	end

	genvar s;
	generate
		for (s = 18; s <= 30; s++) begin : g_div
			localparam int unsigned B = 30 - s;
			logic [44:0] trial;
			logic        qbit;
			logic [12:0] q_prev;
			logic [12:0] q_next;

			assign trial = {1'b0, rem_s[s]} - ({13'd0, d_s[s]} << B);
			assign qbit  = !trial[44];

			if (s == 18) begin : g_q0
				assign q_prev = '0;
			end else begin : g_qn
				assign q_prev = q_s[s];
			end

			always_comb begin
				q_next    = q_prev;
				q_next[B] = qbit;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					q_s[s+1]  <= q_next;
					fn_s[s+1] <= fn_s[s];
					ng_s[s+1] <= ng_s[s];
				end
			end

			if (s < 30) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[s+1] <= qbit ? trial[43:0] : rem_s[s];
						d_s[s+1]   <= d_s[s];
					end
				end
			end
		end
	endgenerate

	// sigmoid mirrors around one half, tanh is odd
	always_ff @(posedge clk) begin
		if (en) begin
			if (fn_s[31] == lcpu_pkg::ACT_TANH) begin
				y_s32 <= ng_s[31] ? -$signed({1'b0, q_s[31]}) : $signed({1'b0, q_s[31]});
			end else begin
				y_s32 <= ng_s[31] ? (14'sd4096 - $signed({1'b0, q_s[31]})) :
					$signed({1'b0, q_s[31]});
			end
		end
	end

	assign y = y_s32;

endmodule

// ===== design/lstm_cell_pointwise_update_top.sv =====
// ----------------------------------------------------------------------------
// lstm cell pointwise update
// gate activations, cell update with write-back and hidden output, q4.12
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (lsb first)                       tuser
//  s_*      in   element_index, initial_cell, input_gate_pre,   req_type
//                forget_gate_pre, candidate_pre, output_gate_pre
//  m_*      out  element_out, hidden_value, cell_value          -
//
//  one word per cycle in while no result is held, only step requests give results
//  latency is set by two 32-stage activation units (17 exp multiplies,
//  13 divide steps) in series around the cell store read-modify-write
//  no clear of the cell store after reset, reads of unloaded elements are undefined
//  a held result stalls the whole pipeline, nothing moves until it is taken
// ----------------------------------------------------------------------------
`include "lstm_cell_pointwise_update_top_macros.svh"

module lstm_cell_pointwise_update_top #(
	parameter int unsigned MAX_ELEMENTS = lcpu_pkg::MAX_ELEMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// element_index, initial_cell, input_gate_pre, forget_gate_pre,
	// candidate_pre, output_gate_pre, zero pad
	input  logic [95:0] s_tdata,
	// req_type
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// element_out, hidden_value, cell_value
	output logic [39:0] m_tdata
);

	localparam int unsigned ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned GATE_S = 1 + lcpu_pkg::ACT_LAT;   // gates ready
	localparam int unsigned WB_S   = GATE_S + 1;              // cell update
	localparam int unsigned BK_S   = WB_S + 1;                // new cell registered
	localparam int unsigned HT_S   = BK_S + lcpu_pkg::ACT_LAT; // tanh of cell ready

	typedef struct packed {
		logic        vld;
		logic        step;
		logic [9:0]  idx;
		logic [9:0]  red;
		logic [15:0] init;
	} front_t;

	typedef struct packed {
		logic               vld;
		logic [9:0]         idx;
		logic signed [13:0] og;
		logic signed [15:0] cval;
	} back_t;

	function automatic logic signed [18:0] rnd_q24(input logic signed [29:0] v);
		logic [29:0] mag;
		logic [17:0] r;
		mag = v[29] ? 30'(-v) : 30'(v);
		r   = 18'((mag + 30'd2048) >> 12);
		return v[29] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	logic en;

	front_t             front_s [1:WB_S];
	back_t              back_s  [BK_S:HT_S];
	logic signed [15:0] gate_s1 [0:3];
	logic signed [13:0] act_y   [0:3];

	logic signed [25:0] p2_s34;
	logic signed [13:0] fg_s34;
	logic signed [13:0] og_s34;
	logic               fwd_vld_s35;
	logic [9:0]         fwd_red_s35;

	logic               out_vld_s68;
	logic [9:0]         out_idx_s68;
	logic signed [13:0] out_h_s68;
	logic signed [15:0] out_cell_s68;

	logic [15:0]        ram_rdata;
	logic signed [15:0] c_old;
	logic signed [29:0] p1;
	logic signed [29:0] sum;
	logic signed [18:0] cn_r;
	logic signed [15:0] nv;
	logic               we;
	logic signed [25:0] p2_c;
	logic signed [13:0] tanh_c;
	logic signed [29:0] hprod;
	logic signed [18:0] h_r;

	assign en       = !out_vld_s68 || m_tready;
	assign s_tready = en;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s[1] <= '0;
		end else if (en) begin
			front_s[1].vld  <= s_tvalid;
			front_s[1].step <= (lcpu_pkg::req_t'(s_tuser[0]) == lcpu_pkg::REQ_STEP);
			front_s[1].idx  <= s_tdata[9:0];
			front_s[1].red  <= s_tdata[9:0];
			front_s[1].init <= s_tdata[25:10];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gate_s1[0] <= s_tdata[41:26];
			gate_s1[1] <= s_tdata[57:42];
			gate_s1[2] <= s_tdata[73:58];
			gate_s1[3] <= s_tdata[89:74];
		end
	end

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_gate
			lcpu_act u_act (
				.clk (clk),
				.en  (en),
				.fn  ((g == 2) ? lcpu_pkg::ACT_TANH : lcpu_pkg::ACT_SIGMOID),
				.x   (gate_s1[g]),
				.y   (act_y[g])
			);
		end
	endgenerate

	// front pipe, element index reduced modulo the store depth on the way
	genvar s;
	generate
		for (s = 1; s < WB_S; s++) begin : g_front
			front_t nxt;
			if (s <= 10) begin : g_red
				localparam longint unsigned LIM = 64'(MAX_ELEMENTS) << (10 - s);
				if (LIM < 64'd1024) begin : g_sub
					always_comb begin
						nxt = front_s[s];
						if (nxt.red >= 10'(LIM)) begin
							nxt.red = nxt.red - 10'(LIM);
						end
					end
				end else begin : g_pass
					assign nxt = front_s[s];
				end
			end else begin : g_plain
				assign nxt = front_s[s];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					front_s[s+1] <= '0;
				end else if (en) begin
					front_s[s+1] <= nxt;
				end
			end
		end
	endgenerate

	// gates ready: i*g product ahead of the cell read
	assign p2_c = act_y[0] * act_y[2];

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s34 <= p2_c;
			fg_s34 <= act_y[1];
			og_s34 <= act_y[3];
		end
	end

	lcpu_ram #(
		.WIDTH (lcpu_pkg::DATA_W),
		.DEPTH (MAX_ELEMENTS)
	) u_cell_ram (
		.clk   (clk),
		.we    (we),
		.waddr (ADDR_W'(front_s[WB_S].red)),
		.wdata (nv),
		.re    (en),
		.raddr (ADDR_W'(front_s[GATE_S].red)),
		.rdata (ram_rdata)
	);

	// the item just ahead wrote on the same edge this one read, take its value
	assign c_old = (fwd_vld_s35 && fwd_red_s35 == front_s[WB_S].red) ?
		back_s[BK_S].cval : $signed(ram_rdata);
	assign p1    = fg_s34 * c_old;
	assign sum   = p1 + 30'(p2_s34);
	assign cn_r  = rnd_q24(sum);

	always_comb begin
		if (!front_s[WB_S].step) begin
			nv = $signed(front_s[WB_S].init);
		end else if (cn_r > 19'sd32767) begin
			nv = 16'sh7fff;
		end else if (cn_r < -19'sd32768) begin
			nv = -16'sh8000;
		end else begin
			nv = cn_r[15:0];
		end
	end

	assign we = en && front_s[WB_S].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_s35  <= 1'b0;
			fwd_red_s35  <= '0;
			back_s[BK_S] <= '0;
		end else if (en) begin
			fwd_vld_s35       <= front_s[WB_S].vld;
			fwd_red_s35       <= front_s[WB_S].red;
			back_s[BK_S].vld  <= front_s[WB_S].vld && front_s[WB_S].step;
			back_s[BK_S].idx  <= front_s[WB_S].idx;
			back_s[BK_S].og   <= og_s34;
			back_s[BK_S].cval <= nv;
		end
	end

	lcpu_act u_cell_tanh (
		.clk (clk),
		.en  (en),
		.fn  (lcpu_pkg::ACT_TANH),
		.x   (back_s[BK_S].cval),
		.y   (tanh_c)
	);

	generate
		for (s = BK_S; s < HT_S; s++) begin : g_back
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					back_s[s+1] <= '0;
				end else if (en) begin
					back_s[s+1] <= back_s[s];
				end
			end
		end
	endgenerate

	assign hprod = back_s[HT_S].og * tanh_c;
	assign h_r   = rnd_q24(hprod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s68 <= 1'b0;
		end else if (en) begin
			out_vld_s68 <= back_s[HT_S].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_idx_s68  <= back_s[HT_S].idx;
			out_h_s68    <= h_r[13:0];
			out_cell_s68 <= back_s[HT_S].cval;
		end
	end

	assign m_tvalid = out_vld_s68;
	assign m_tdata  = {out_cell_s68, out_h_s68, out_idx_s68};

	`LCPU_ASSERT_IMP(a_hidden_range, m_tvalid, ($signed(m_tdata[23:10]) >= -14'sd4096) && ($signed(m_tdata[23:10]) <= 14'sd4096))
	`LCPU_ASSERT_NXT(a_load_silent, en && front_s[WB_S].vld && !front_s[WB_S].step, !back_s[BK_S].vld)
	`LCPU_ASSERT_IMP(a_addr_range, front_s[11].vld, 32'(front_s[11].red) < 32'(MAX_ELEMENTS))
	`LCPU_ASSERT_NXT(a_stall_hold, !en, $stable(back_s[BK_S].cval) && $stable(fwd_vld_s35))

endmodule
